### rtl/lz77_triple_encoder_core_assert.svh
// ---------------------------------------------------------------------------
// LZ77 triple encoder assertion macros
// Shared concurrent assertion forms, clocked on clk and disabled in reset.
// ---------------------------------------------------------------------------
`ifndef LZ77_TRIPLE_ENCODER_CORE_ASSERT_SVH
`define LZ77_TRIPLE_ENCODER_CORE_ASSERT_SVH

`define LZ77TE_ASSERT_ALWAYS(name, cond, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
        else $error(msg);

`define LZ77TE_ASSERT_IMPLY(name, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

`define LZ77TE_ASSERT_NEXT(name, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### rtl/lz77te_pkg.sv
// ---------------------------------------------------------------------------
// LZ77 triple encoder package
// Types and fixed constants shared by the history cells, the search unit
// and the top level.
// ---------------------------------------------------------------------------
package lz77te_pkg;

    localparam int BYTE_W   = 8;
    localparam int GRP_SIZE = 16;
    localparam int GRP_W    = 4;
    localparam int TDATA_W  = 24;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_GROUP,
        ST_SCAN
    } state_t;

    typedef struct packed {
        logic shift;
        logic start;
        logic extend;
        logic flush;
        logic clear;
    } cell_ctl_t;

    typedef struct packed {
        logic start;
        logic run;
    } srch_ctl_t;

    typedef struct packed {
        logic done;
        logic found;
    } srch_stat_t;

    typedef struct packed {
        logic              fin;
        logic [BYTE_W-1:0] lit;
        logic [BYTE_W-1:0] len;
        logic [BYTE_W-1:0] off;
    } triple_t;

endpackage

### rtl/lz77_triple_encoder_core.sv
// ---------------------------------------------------------------------------
// LZ77 triple encoder core
// Greedy longest-match LZ77 parser over a sliding byte history that emits
// (offset, length, next literal) triples.
// ---------------------------------------------------------------------------
// A byte that extends an open match or yields a plain literal triple is
// taken in ST_IDLE. A byte that closes a match passes through ST_GROUP and
// ST_SCAN, and its triple is pushed once the output queue has room: the
// group priority register and the block scan of the search unit, over NB =
// ceil(WINDOW_SIZE / 256) blocks, pick the oldest live distance. All window
// distances are compared in parallel by a row of history cells. Results wait
// in a two-entry output queue, so the next byte is taken while one triple is
// still pending, and input is held off while both entries are full. Offset
// and length are carried in 8 bits each on the output.
// ---------------------------------------------------------------------------
`include "lz77_triple_encoder_core_assert.svh"

module lz77_triple_encoder_core
    import lz77te_pkg::*;
#(
    parameter int WINDOW_SIZE = 255,
    parameter int MAX_MATCH   = 255
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               s_tvalid,
    output logic               s_tready,
    input  logic [BYTE_W-1:0]  s_tdata,   // [7:0] data_byte
    input  logic               s_tlast,   // last_byte
    output logic               m_tvalid,
    input  logic               m_tready,
    output logic [TDATA_W-1:0] m_tdata,   // [7:0] match_offset, [15:8] match_length,
                                          // [23:16] next_literal
    output logic               m_tlast    // final_triple
);

    localparam int OFF_W = $clog2(WINDOW_SIZE + 1);
    localparam int LEN_W = $clog2(MAX_MATCH + 1);

    cell_ctl_t               cell_ctl;
    srch_ctl_t               srch_ctl;
    srch_stat_t              stat;
    logic [OFF_W-1:0]        srch_offset;
    logic [BYTE_W-1:0]       hist_bytes [WINDOW_SIZE];
    logic [WINDOW_SIZE-1:0]  hist_valid;
    logic [WINDOW_SIZE-1:0]  alive_vec;
    logic [WINDOW_SIZE-1:0]  hit_vec;
    logic [WINDOW_SIZE-1:0]  ahit_vec;

    state_t                  state_reg;
    state_t                  state_next;
    logic [LEN_W-1:0]        len_reg;
    logic [LEN_W-1:0]        len_next;
    logic [LEN_W-1:0]        pend_len_reg;
    logic [LEN_W-1:0]        pend_len_next;
    logic [BYTE_W-1:0]       pend_lit_reg;
    logic [BYTE_W-1:0]       pend_lit_next;
    logic                    pend_fin_reg;
    logic                    pend_fin_next;

    triple_t                 q_mem_reg [2];
    logic                    wr_ptr_reg;
    logic                    rd_ptr_reg;
    logic [1:0]              q_cnt_reg;
    logic [1:0]              q_cnt_next;
    triple_t                 q_head;
    triple_t                 push_data;
    logic                    push;
    logic                    pop;

    logic                    s_acc;
    logic                    any_start;
    logic                    any_cont;
    logic                    len_zero;
    logic                    len_cap;
    logic [LEN_W-1:0]        len_inc;
    logic [OFF_W+BYTE_W-1:0] off_ext;
    logic [LEN_W+BYTE_W-1:0] len_ext;

    for (genvar i = 0; i < WINDOW_SIZE; i++)
    begin : g_cell
        if (i == 0)
        begin : g_head
            lz77te_cell u_cell (
                .clk        (clk),
                .rst_n      (rst_n),
                .ctl        (cell_ctl),
                .data_byte  (s_tdata),
                .prev_byte  (s_tdata),
                .prev_valid (1'b1),
                .hist_byte  (hist_bytes[i]),
                .hist_valid (hist_valid[i]),
                .alive      (alive_vec[i]),
                .hit        (hit_vec[i]),
                .alive_hit  (ahit_vec[i])
            );
        end
        else
        begin : g_body
            lz77te_cell u_cell (
                .clk        (clk),
                .rst_n      (rst_n),
                .ctl        (cell_ctl),
                .data_byte  (s_tdata),
                .prev_byte  (hist_bytes[i-1]),
                .prev_valid (hist_valid[i-1]),
                .hist_byte  (hist_bytes[i]),
                .hist_valid (hist_valid[i]),
                .alive      (alive_vec[i]),
                .hit        (hit_vec[i]),
                .alive_hit  (ahit_vec[i])
            );
        end
    end

    lz77te_search #(
        .WINDOW_SIZE (WINDOW_SIZE)
    ) u_search (
        .clk       (clk),
        .rst_n     (rst_n),
        .ctl       (srch_ctl),
        .alive_vec (alive_vec),
        .stat      (stat),
        .offset    (srch_offset)
    );

    assign s_tready  = (state_reg == ST_IDLE) && (q_cnt_reg != 2'd2);
    assign s_acc     = s_tvalid && s_tready;
    assign any_start = |hit_vec;
    assign any_cont  = |ahit_vec;
    assign len_zero  = (len_reg == '0);
    assign len_cap   = (len_reg == LEN_W'(MAX_MATCH));
    assign len_inc   = len_reg + LEN_W'(1);
    assign off_ext   = {{BYTE_W{1'b0}}, srch_offset};
    assign len_ext   = {{BYTE_W{1'b0}}, pend_len_reg};

    always_comb
    begin
        state_next    = state_reg;
        len_next      = len_reg;
        pend_len_next = pend_len_reg;
        pend_lit_next = pend_lit_reg;
        pend_fin_next = pend_fin_reg;
        cell_ctl      = '0;
        srch_ctl      = '0;
        push          = 1'b0;
        push_data     = '0;

        unique case (state_reg)
            ST_IDLE:
            begin
                cell_ctl.shift = s_acc;
                cell_ctl.flush = s_acc && s_tlast;
                if (s_acc)
                begin
                    priority if (len_zero)
                    begin
                        cell_ctl.start = 1'b1;
                        if (!any_start)
                        begin
                            push          = 1'b1;
                            push_data.fin = s_tlast;
                            push_data.lit = s_tdata;
                        end
                        else
                        begin
                            len_next = LEN_W'(1);
                            if (s_tlast)
                            begin
                                pend_len_next = LEN_W'(1);
                                pend_lit_next = '0;
                                pend_fin_next = 1'b1;
                                state_next    = ST_GROUP;
                            end
                        end
                    end
                    else if (len_cap || !any_cont)
                    begin
                        pend_len_next = len_reg;
                        pend_lit_next = s_tdata;
                        pend_fin_next = s_tlast;
                        len_next      = '0;
                        state_next    = ST_GROUP;
                    end
                    else
                    begin
                        cell_ctl.extend = 1'b1;
                        len_next        = len_inc;
                        if (s_tlast)
                        begin
                            pend_len_next = len_inc;
                            pend_lit_next = '0;
                            pend_fin_next = 1'b1;
                            state_next    = ST_GROUP;
                        end
                    end
                    if (s_tlast)
                    begin
                        len_next = '0;
                    end
                end
            end
            ST_GROUP:
            begin
                srch_ctl.start = 1'b1;
                state_next     = ST_SCAN;
            end
            ST_SCAN:
            begin
                srch_ctl.run = 1'b1;
                if (stat.done && (q_cnt_reg != 2'd2))
                begin
                    push           = 1'b1;
                    push_data.off  = off_ext[BYTE_W-1:0];
                    push_data.len  = len_ext[BYTE_W-1:0];
                    push_data.lit  = pend_lit_reg;
                    push_data.fin  = pend_fin_reg;
                    cell_ctl.clear = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign q_head   = q_mem_reg[rd_ptr_reg];
    assign m_tvalid = (q_cnt_reg != 2'd0);
    assign m_tdata  = {q_head.lit, q_head.len, q_head.off};
    assign m_tlast  = q_head.fin;
    assign pop      = m_tvalid && m_tready;

    always_comb
    begin
        q_cnt_next = q_cnt_reg;
        if (push && !pop)
        begin
            q_cnt_next = q_cnt_reg + 2'd1;
        end
        else if (pop && !push)
        begin
            q_cnt_next = q_cnt_reg - 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_IDLE;
            len_reg    <= '0;
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            q_cnt_reg  <= 2'd0;
        end
        else
        begin
            state_reg <= state_next;
            len_reg   <= len_next;
            q_cnt_reg <= q_cnt_next;
            if (push)
            begin
                wr_ptr_reg <= !wr_ptr_reg;
            end
            if (pop)
            begin
                rd_ptr_reg <= !rd_ptr_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        pend_len_reg <= pend_len_next;
        pend_lit_reg <= pend_lit_next;
        pend_fin_reg <= pend_fin_next;
        if (push)
        begin
            q_mem_reg[wr_ptr_reg] <= push_data;
        end
    end

    `LZ77TE_ASSERT_NEXT(a_last_ends_token, s_acc && s_tlast, len_reg == '0,
        "Match length not cleared after the final byte.")
    `LZ77TE_ASSERT_IMPLY(a_scan_finds, (state_reg == ST_SCAN) && stat.done, stat.found,
        "Search finished without a live candidate.")
    `LZ77TE_ASSERT_IMPLY(a_open_token_live, (state_reg == ST_IDLE) && !len_zero, |alive_vec,
        "Open match has no live candidate.")
    `LZ77TE_ASSERT_ALWAYS(a_len_bound, len_reg <= LEN_W'(MAX_MATCH),
        "Match length exceeds the cap.")

endmodule

### rtl/lz77te_cell.sv
// ---------------------------------------------------------------------------
// LZ77 history cell
// Holds one history byte with its valid flag and the live flag of the match
// candidate at this distance, and passes its byte on to the next cell.
// ---------------------------------------------------------------------------
module lz77te_cell
    import lz77te_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  cell_ctl_t         ctl,
    input  logic [BYTE_W-1:0] data_byte,
    input  logic [BYTE_W-1:0] prev_byte,
    input  logic              prev_valid,
    output logic [BYTE_W-1:0] hist_byte,
    output logic              hist_valid,
    output logic              alive,
    output logic              hit,
    output logic              alive_hit
);

    logic [BYTE_W-1:0] hist_reg;
    logic [BYTE_W-1:0] hist_next;
    logic              valid_reg;
    logic              valid_next;
    logic              alive_reg;
    logic              alive_next;

    always_comb
    begin
        hit       = valid_reg && (hist_reg == data_byte);
        alive_hit = alive_reg && hit;

        hist_next  = hist_reg;
        valid_next = valid_reg;
        if (ctl.shift)
        begin
            hist_next  = prev_byte;
            valid_next = ctl.flush ? 1'b0 : prev_valid;
        end

        priority if (ctl.clear)
        begin
            alive_next = 1'b0;
        end
        else if (ctl.start)
        begin
            alive_next = hit;
        end
        else if (ctl.extend)
        begin
            alive_next = alive_hit;
        end
        else
        begin
            alive_next = alive_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            alive_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
            alive_reg <= alive_next;
        end
    end

    always_ff @(posedge clk)
    begin
        hist_reg <= hist_next;
    end

    assign hist_byte  = hist_reg;
    assign hist_valid = valid_reg;
    assign alive      = alive_reg;

endmodule

### rtl/lz77te_search.sv
// ---------------------------------------------------------------------------
// LZ77 oldest candidate search
// Registers the highest live distance of every group of sixteen cells, then
// scans blocks of sixteen groups from the top down, one block per cycle.
// ---------------------------------------------------------------------------
module lz77te_search
    import lz77te_pkg::*;
#(
    parameter int WINDOW_SIZE = 255,
    localparam int OFF_W = $clog2(WINDOW_SIZE + 1)
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  srch_ctl_t              ctl,
    input  logic [WINDOW_SIZE-1:0] alive_vec,
    output srch_stat_t             stat,
    output logic [OFF_W-1:0]       offset
);

    localparam int NG    = (WINDOW_SIZE + GRP_SIZE - 1) / GRP_SIZE;
    localparam int NB    = (NG + GRP_SIZE - 1) / GRP_SIZE;
    localparam int BLK_W = (NB > 1) ? $clog2(NB) : 1;
    localparam int NGP   = (1 << BLK_W) * GRP_SIZE;
    localparam int POS_W = BLK_W + 2 * GRP_W + 1;

    logic [NG*GRP_SIZE-1:0] alive_pad;
    logic                   grp_any_next [NGP];
    logic [GRP_W-1:0]       grp_idx_next [NGP];
    logic                   grp_any_reg  [NGP];
    logic [GRP_W-1:0]       grp_idx_reg  [NGP];
    logic [BLK_W-1:0]       blk_reg;
    logic [BLK_W-1:0]       blk_next;
    logic                   found;
    logic [GRP_W-1:0]       jsel;
    logic [GRP_W-1:0]       isel;
    logic [POS_W-1:0]       pos;

    assign alive_pad = (NG * GRP_SIZE)'(alive_vec);

    always_comb
    begin
        for (int g = 0; g < NGP; g++)
        begin
            grp_any_next[g] = 1'b0;
            grp_idx_next[g] = '0;
        end
        for (int g = 0; g < NG; g++)
        begin
            for (int k = 0; k < GRP_SIZE; k++)
            begin
                if (alive_pad[g*GRP_SIZE+k])
                begin
                    grp_any_next[g] = 1'b1;
                    grp_idx_next[g] = GRP_W'(k);
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        for (int g = 0; g < NGP; g++)
        begin
            grp_any_reg[g] <= grp_any_next[g];
            grp_idx_reg[g] <= grp_idx_next[g];
        end
    end

    always_comb
    begin
        found = 1'b0;
        jsel  = '0;
        isel  = '0;
        for (int j = 0; j < GRP_SIZE; j++)
        begin
            if (grp_any_reg[{blk_reg, GRP_W'(j)}])
            begin
                found = 1'b1;
                jsel  = GRP_W'(j);
                isel  = grp_idx_reg[{blk_reg, GRP_W'(j)}];
            end
        end
        pos         = {1'b0, blk_reg, jsel, isel} + POS_W'(1);
        offset      = pos[OFF_W-1:0];
        stat.found  = found;
        stat.done   = found || (blk_reg == '0);

        blk_next = blk_reg;
        priority if (ctl.start)
        begin
            blk_next = BLK_W'(NB - 1);
        end
        else if (ctl.run && !stat.done)
        begin
            blk_next = blk_reg - BLK_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            blk_reg <= '0;
        end
        else
        begin
            blk_reg <= blk_next;
        end
    end

endmodule
